/* src/positional_array_insert_delete_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the positional array insert/delete block
// Concurrent assertion wrappers, clocked on clk_i; PAID_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PAID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define PAID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PAID_ASSERT(lbl, prop, msg)
`define PAID_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/paid_pkg.sv */
// ----------------------------------------------------------------------------
// paid_pkg
// Types and constants shared by the positional array insert/delete block.
// ----------------------------------------------------------------------------
package paid_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 6;
  // Wide enough for any cell index or count over the whole capacity range.
  localparam int unsigned IDX_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } paid_op_e;

  // Command broadcast to every cell. For a rotate, pos is the last live index.
  typedef struct packed {
    paid_op_e                op;
    logic [IDX_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } paid_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } paid_state_e;

endpackage

/* src/paid_cell.sv */
// ----------------------------------------------------------------------------
// paid_cell
// One slot of the store: holds an entry and takes from a neighbor on command.
// ----------------------------------------------------------------------------
module paid_cell
  import paid_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  paid_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  input  logic signed [VAL_W-1:0] head_i,
  output logic signed [VAL_W-1:0] entry_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic signed [VAL_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (MyIdx > cmd_i.pos) begin
          entry_d = left_i;
        end else if (MyIdx == cmd_i.pos) begin
          entry_d = cmd_i.value;
        end
      end
      OP_DELETE: begin
        if (MyIdx >= cmd_i.pos) begin
          entry_d = right_i;
        end
      end
      OP_ROTATE: begin
        // The live entries turn one place toward the head; the head wraps.
        if (MyIdx < cmd_i.pos) begin
          entry_d = right_i;
        end else if (MyIdx == cmd_i.pos) begin
          entry_d = head_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* src/positional_array_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// Ordered store of signed words with insert, delete and read out by position.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells, each shifting to or from its neighbor
// under one broadcast command, so an insert or delete updates all cells at
// once and gives one registered status word in the cycle after it is taken;
// a new input word may then follow unless the output is stalled. A read out
// walks the live entries by rotating them through the head cell, one output
// word per cycle while the output is not stalled; the rotation leaves the
// order as it was. Input stall is held during a read out and whenever the
// output register is full and stalled. No clearing pass is needed after
// reset.
`include "positional_array_insert_delete_defines.svh"

module positional_array_insert_delete
  import paid_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] entry_value_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    last_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  paid_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;

  logic                    out_valid_q, out_valid_d;
  logic [ST_W-1:0]         status_q, status_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [CW-1:0]           ocount_q, ocount_d;
  logic                    last_q, last_d;
  logic                    load;

  paid_cmd_t cmd;
  logic signed [VAL_W-1:0] entry_w [CAPACITY];

  logic out_free, in_acc, rd_last;
  logic [CMPW-1:0] pos_ext, cnt_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_ext    = CMPW'(position_i);
  assign cnt_ext    = CMPW'(count_q);
  assign rd_last    = (CW'(rd_idx_q) == count_q - CW'(1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmd.op    = OP_HOLD;
    cmd.pos   = IDX_W'(position_i);
    cmd.value = value_i;
    load      = 1'b0;
    status_d  = ST_DONE;
    value_d   = '0;
    last_d    = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            MODE_INSERT: begin
              load = 1'b1;
              if (count_q == Cap) begin
                status_d = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
              end else begin
                cmd.op  = OP_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            MODE_DELETE: begin
              load = 1'b1;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                status_d = ST_BADPOS;
              end else begin
                cmd.op  = OP_DELETE;
                count_d = count_q - CW'(1);
              end
            end
            MODE_READ: begin
              if (count_q == '0) begin
                load     = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d  = S_READ;
                rd_idx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load     = 1'b1;
          value_d  = entry_w[0];
          last_d   = rd_last;
          cmd.op   = OP_ROTATE;
          cmd.pos  = IDX_W'(count_q - CW'(1));
          rd_idx_d = rd_idx_q + IW'(1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    ocount_d = count_d;
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      value_q  <= value_d;
      ocount_q <= ocount_d;
      last_q   <= last_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = entry_w[i];
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    paid_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (entry_w[0]),
      .entry_o(entry_w[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = value_q;
  assign entry_count_o = CNT_W'(ocount_q);
  assign last_o        = last_q;

  `PAID_ASSERT(a_count_bound, count_q <= Cap, "live count exceeds capacity")
  `PAID_ASSERT(a_read_stalls, (state_q == S_READ) |-> in_stall_o,
               "input taken during read out")
  `PAID_ASSERT(a_read_idx, (state_q == S_READ) |-> (CW'(rd_idx_q) < count_q),
               "read index past count")
  `PAID_ASSERT(a_insert_grows,
               (in_acc && mode_i == MODE_INSERT && count_q != Cap && pos_ext <= cnt_ext)
                 |=> (count_q == $past(count_q) + CW'(1)),
               "insert did not grow count")

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for positional_array_insert_delete
// Drives insert, delete, read out and unused mode words into the block with
// random gaps on both sides. A scoreboard keeps its own copy of the ordered
// store, derives the status words and read out entries each accepted input
// word should cause, and checks every output word against them in order.
// ----------------------------------------------------------------------------
module testbench;
  import paid_pkg::*;

  localparam int STORE_DEPTH = 32;
  localparam int STALL_LIMIT = 2000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_BLEND = 2;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } store_word_t;

  class store_scoreboard;
    logic signed [VAL_W-1:0] slots [STORE_DEPTH];
    int unsigned             fill;
    store_word_t             pending[$];
    int                      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void push_word(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] v,
                            logic lst);
      store_word_t w;
      w.status      = st;
      w.entry_value = v;
      w.entry_count = CNT_W'(fill);
      w.last        = lst;
      pending.push_back(w);
    endfunction

    // Applies one accepted input word to the shadow store.
    function void note_input(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                             logic signed [VAL_W-1:0] val);
      case (mode)
        MODE_INSERT: begin
          if (fill >= STORE_DEPTH) begin
            push_word(ST_FULL, '0, 1'b1);
          end else if (pos > fill) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else begin
            for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            fill++;
            push_word(ST_DONE, '0, 1'b1);
          end
        end
        MODE_DELETE: begin
          if (fill == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else if (pos >= fill) begin
            push_word(ST_BADPOS, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            push_word(ST_DONE, '0, 1'b1);
          end
        end
        MODE_READ: begin
          if (fill == 0) begin
            push_word(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) push_word(ST_DONE, slots[i], i + 1 == fill);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] v,
                               logic [CNT_W-1:0] cnt, logic lst);
      store_word_t w;
      if (pending.size() == 0) begin
        $error("output word with nothing expected: status %0d value %0d", st, v);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (st !== w.status) begin
        $error("status mismatch: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (v !== w.entry_value) begin
        $error("entry_value mismatch: expected %0d, got %0d", w.entry_value, v);
        errors++;
      end
      if (cnt !== w.entry_count) begin
        $error("entry_count mismatch: expected %0d, got %0d", w.entry_count, cnt);
        errors++;
      end
      if (lst !== w.last) begin
        $error("last mismatch: expected %0d, got %0d", w.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [MODE_W-1:0]       mode_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [ST_W-1:0]         status_o;
  logic signed [VAL_W-1:0] entry_value_o;
  logic [CNT_W-1:0]        entry_count_o;
  logic                    last_o;

  store_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              quiet_cycles;

  positional_array_insert_delete #(
    .CAPACITY(STORE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .entry_count_o(entry_count_o),
    .last_o       (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output side back pressure, redrawn every cycle.
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(mode_i, position_i, value_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, entry_value_o, entry_count_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_word(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
                            logic signed [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic random_word(int mix);
    int                      roll;
    int unsigned             cnt;
    logic [MODE_W-1:0]       m;
    logic [POS_W-1:0]        p;
    roll = $urandom_range(99);
    cnt  = sb.fill;
    case (mix)
      MIX_FILL:  m = roll < 88 ? MODE_INSERT : roll < 94 ? MODE_DELETE :
                     roll < 99 ? MODE_READ : MODE_UNUSED;
      MIX_DRAIN: m = roll < 15 ? MODE_INSERT : roll < 85 ? MODE_DELETE :
                     roll < 97 ? MODE_READ : MODE_UNUSED;
      default:   m = roll < 40 ? MODE_INSERT : roll < 75 ? MODE_DELETE :
                     roll < 95 ? MODE_READ : MODE_UNUSED;
    endcase
    // Mostly legal positions, sometimes anything the field can carry.
    if ($urandom_range(9) < 8) begin
      if (m == MODE_INSERT) p = POS_W'($urandom_range(cnt));
      else p = cnt == 0 ? '0 : POS_W'($urandom_range(cnt - 1));
    end else begin
      p = POS_W'($urandom_range(63));
    end
    drive_word(m, p, $urandom);
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 28;
    recv_idle_pct = 49;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_INSERT;
    position_i    = '0;
    value_i       = '0;
    out_stall_i   = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty store, bad positions, extreme values, both ends.
    drive_word(MODE_READ, '0, '0);
    drive_word(MODE_DELETE, '0, '0);
    drive_word(MODE_DELETE, 6'd63, '0);
    drive_word(MODE_INSERT, 6'd1, 32'sd5);
    drive_word(MODE_INSERT, 6'd63, 32'sd5);
    drive_word(MODE_INSERT, '0, 32'sh8000_0000);
    drive_word(MODE_INSERT, 6'd1, 32'sh7fff_ffff);
    drive_word(MODE_INSERT, '0, -32'sd1);
    drive_word(MODE_INSERT, 6'd1, 32'sd0);
    drive_word(MODE_INSERT, 6'd4, 32'sh5555_aaaa);
    drive_word(MODE_READ, '0, '0);
    drive_word(MODE_DELETE, 6'd5, '0);
    drive_word(MODE_DELETE, 6'd63, '0);
    drive_word(MODE_DELETE, 6'd2, '0);
    drive_word(MODE_UNUSED, 6'd63, 32'sh7fff_ffff);
    drive_word(MODE_DELETE, 6'd3, '0);
    drive_word(MODE_DELETE, '0, '0);
    drive_word(MODE_READ, 6'd63, -32'sd1);

    for (int k = 0; k < 240; k++) begin
      if (k == 80) begin
        send_idle_pct = 49;
        recv_idle_pct = 28;
      end else if (k == 160) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_word((k / 40) % 3);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
